// File: rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefixed link deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

    // Configuration register map
    typedef enum logic [1:0] {
        REG_MAX_PAYLOAD_LEN   = 2'd0,
        REG_LINK_IDENTIFIER   = 2'd1,
        REG_MIN_MAJOR_VERSION = 2'd2
    } t_reg_index;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [15:0] MAX_PAYLOAD_LEN_RST   = 16'd1496;
    localparam logic [31:0] LINK_IDENTIFIER_RST   = 32'h8a65_6c70;
    localparam logic [15:0] MIN_MAJOR_VERSION_RST = 16'd1;

    // Result kinds
    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_EMPTY     = 3'd1;
    localparam logic [2:0] KIND_HS_ACCEPT = 3'd2;
    localparam logic [2:0] KIND_HS_REJECT = 3'd3;
    localparam logic [2:0] KIND_LEN_ERROR = 3'd4;

    // Handshake reply byte positions
    localparam logic [3:0] HS_CMD_FIRST = 4'd4;
    localparam logic [3:0] HS_VER_FIRST = 4'd8;
    localparam logic [3:0] HS_VER_HIGH  = 4'd8;
    localparam logic [3:0] HS_VER_LOW   = 4'd9;
    localparam logic [3:0] HS_LAST      = 4'd11;

    // Frame header byte positions
    localparam logic [3:0] HDR_STATUS   = 4'd1;
    localparam logic [3:0] HDR_LEN_HIGH = 4'd2;
    localparam logic [3:0] HDR_LEN_LOW  = 4'd3;

    typedef enum logic [3:0] {
        PH_HANDSHAKE = 4'b0001,
        PH_HEADER    = 4'b0010,
        PH_PAYLOAD   = 4'b0100,
        PH_ERROR     = 4'b1000
    } t_phase;

endpackage

`default_nettype wire

// File: rtl/lpd_rx_if.sv
// ----------------------------------------------------------------------------
// lpd_rx_if
// Byte stream channel into the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/lpd_res_if.sv
// ----------------------------------------------------------------------------
// lpd_res_if
// Result channel out of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpd_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [7:0]  frame_status;
    logic        last;
    logic [15:0] frame_length;

    modport source (output valid, output kind, output data, output frame_status,
                    output last, output frame_length, input ready);
    modport sink   (input valid, input kind, input data, input frame_status,
                    input last, input frame_length, output ready);
endinterface

`default_nettype wire

// File: rtl/length_prefixed_link_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_link_deframer
// Checks a 12-byte handshake reply, then splits the byte stream into
// length-prefixed frames and emits payload bytes with status and last flag.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while i_rx.ready is high. The byte is
// decoded against the phase and counters combinationally and its result, if
// any, is loaded into the output register at the transfer. i_rx.ready is
// high whenever that register is empty or is being taken in the same cycle,
// so a stream runs at one byte per cycle as long as the result sink keeps up.
// A rejected handshake or an oversized length leaves the block in an error
// phase that swallows all bytes until reset.
`default_nettype none

module length_prefixed_link_deframer
    import lpd_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    lpd_rx_if.sink                 i_rx,
    lpd_res_if.source              o_res
);

    // configuration
    logic [15:0] r_max_len;
    logic [31:0] r_link_id;
    logic [15:0] r_min_major;

    // deframer state
    t_phase      r_phase,         n_phase;
    logic [3:0]  r_byte_count,    n_byte_count;
    logic        r_mismatch,      n_mismatch;
    logic [7:0]  r_version_high,  n_version_high;
    logic [7:0]  r_header_status, n_header_status;
    logic [7:0]  r_length_high,   n_length_high;
    logic [15:0] r_header_length, n_header_length;
    logic [15:0] r_remaining,     n_remaining;

    // output register
    logic        r_out_valid;
    logic [2:0]  r_kind,   n_kind;
    logic [7:0]  r_data,   n_data;
    logic [7:0]  r_status, n_status;
    logic        r_last,   n_last;
    logic [15:0] r_length, n_length;
    logic        res_fire;

    logic        in_xfer;
    logic [7:0]  b;
    logic [7:0]  id_byte;
    logic [15:0] rx_length;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign in_xfer    = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;

    // expected identifier byte, most significant first
    assign id_byte   = 8'(r_link_id >> {2'(2'd3 - r_byte_count[1:0]), 3'b000});
    assign rx_length = {r_length_high, b};

    always_comb begin
        n_phase         = r_phase;
        n_byte_count    = r_byte_count;
        n_mismatch      = r_mismatch;
        n_version_high  = r_version_high;
        n_header_status = r_header_status;
        n_length_high   = r_length_high;
        n_header_length = r_header_length;
        n_remaining     = r_remaining;
        res_fire        = 1'b0;
        n_kind          = KIND_PAYLOAD;
        n_data          = 8'd0;
        n_status        = 8'd0;
        n_last          = 1'b0;
        n_length        = 16'd0;

        unique case (r_phase)
            PH_HANDSHAKE: begin
                if (r_byte_count < HS_CMD_FIRST) begin
                    if (b != id_byte) n_mismatch = 1'b1;
                end else if (r_byte_count < HS_VER_FIRST) begin
                    if (b != 8'd0) n_mismatch = 1'b1;
                end else if (r_byte_count == HS_VER_HIGH) begin
                    n_version_high = b;
                end else if (r_byte_count == HS_VER_LOW) begin
                    if ({r_version_high, b} < r_min_major) n_mismatch = 1'b1;
                end
                if (r_byte_count >= HS_LAST) begin
                    res_fire     = 1'b1;
                    n_byte_count = 4'd0;
                    n_phase      = r_mismatch ? PH_ERROR : PH_HEADER;
                    n_kind       = r_mismatch ? KIND_HS_REJECT : KIND_HS_ACCEPT;
                end else begin
                    n_byte_count = r_byte_count + 4'd1;
                end
            end
            PH_HEADER: begin
                if (r_byte_count >= HDR_LEN_LOW) begin
                    n_header_length = rx_length;
                    n_byte_count    = 4'd0;
                    n_status        = r_header_status;
                    if (rx_length > r_max_len) begin
                        res_fire = 1'b1;
                        n_kind   = KIND_LEN_ERROR;
                        n_length = rx_length;
                        n_phase  = PH_ERROR;
                    end else if (rx_length == 16'd0) begin
                        res_fire = 1'b1;
                        n_kind   = KIND_EMPTY;
                        n_last   = 1'b1;
                    end else begin
                        n_remaining = rx_length;
                        n_phase     = PH_PAYLOAD;
                    end
                end else begin
                    if (r_byte_count == HDR_STATUS)   n_header_status = b;
                    if (r_byte_count == HDR_LEN_HIGH) n_length_high   = b;
                    n_byte_count = r_byte_count + 4'd1;
                end
            end
            PH_PAYLOAD: begin
                res_fire    = 1'b1;
                n_kind      = KIND_PAYLOAD;
                n_data      = b;
                n_status    = r_header_status;
                n_length    = r_header_length;
                n_last      = (r_remaining <= 16'd1);
                n_remaining = r_remaining - 16'd1;
                if (r_remaining <= 16'd1) begin
                    n_remaining  = 16'd0;
                    n_phase      = PH_HEADER;
                    n_byte_count = 4'd0;
                end
            end
            PH_ERROR: begin
                // sticky: bytes are dropped
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len       <= MAX_PAYLOAD_LEN_RST;
            r_link_id       <= LINK_IDENTIFIER_RST;
            r_min_major     <= MIN_MAJOR_VERSION_RST;
            r_phase         <= PH_HANDSHAKE;
            r_byte_count    <= 4'd0;
            r_mismatch      <= 1'b0;
            r_version_high  <= 8'd0;
            r_header_status <= 8'd0;
            r_length_high   <= 8'd0;
            r_header_length <= 16'd0;
            r_remaining     <= 16'd0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MAX_PAYLOAD_LEN:   r_max_len   <= i_cfg_data[15:0];
                    REG_LINK_IDENTIFIER:   r_link_id   <= i_cfg_data;
                    REG_MIN_MAJOR_VERSION: r_min_major <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_xfer) begin
                r_phase         <= n_phase;
                r_byte_count    <= n_byte_count;
                r_mismatch      <= n_mismatch;
                r_version_high  <= n_version_high;
                r_header_status <= n_header_status;
                r_length_high   <= n_length_high;
                r_header_length <= n_header_length;
                r_remaining     <= n_remaining;
            end
            if (in_xfer && res_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer && res_fire) begin
            r_kind   <= n_kind;
            r_data   <= n_data;
            r_status <= n_status;
            r_last   <= n_last;
            r_length <= n_length;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_kind;
    assign o_res.data         = r_data;
    assign o_res.frame_status = r_status;
    assign o_res.last         = r_last;
    assign o_res.frame_length = r_length;

endmodule

`default_nettype wire

// File: tb/sv/length_prefixed_link_deframer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_link_deframer_test
// Self-checking bench for the link deframer. One reset, then a short scripted
// handshake and a few frames, then random frame streams over several register
// settings and idle patterns, ending in a length error and swallowed bytes.
// Every result is compared with a fixed script row or a copy of the deframer.
// ----------------------------------------------------------------------------

module length_prefixed_link_deframer_test;
    import lpd_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 2000;

    // index with no register behind it; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [7:0]  status;
        logic        last;
        logic [15:0] length;
    } t_frame_result;

    localparam t_frame_result NO_RESULT = '0;

    typedef enum bit {STEP_BYTE, STEP_REG} t_script_op;

    typedef struct {
        t_script_op              op;
        logic [CFG_INDEX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0]   value;
        bit                      fixed;
        bit                      has_res;
        t_frame_result           res;
    } t_script_row;

    localparam int SCRIPT_LEN = 24;

    // Handshake checked against the reset identifier for its first four bytes,
    // then registers change mid-reply; minor and revision bytes are not checked.
    t_script_row script [SCRIPT_LEN] = '{
        '{STEP_BYTE, 2'd0, 32'h8a, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h65, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h6c, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h70, 1'b1, 1'b0, NO_RESULT},
        '{STEP_REG, REG_LINK_IDENTIFIER, 32'h0000_0000, 1'b1, 1'b0, NO_RESULT},
        '{STEP_REG, REG_MIN_MAJOR_VERSION, 32'h0000_ffff, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h00, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h00, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h00, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h00, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'hff, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'hff, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h00, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'hff, 1'b1, 1'b1,
          '{KIND_HS_ACCEPT, 8'h00, 8'h00, 1'b0, 16'h0000}},
        // empty frame
        '{STEP_BYTE, 2'd0, 32'h00, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'hff, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h00, 1'b1, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h00, 1'b1, 1'b1,
          '{KIND_EMPTY, 8'h00, 8'hff, 1'b1, 16'h0000}},
        // two-byte frame
        '{STEP_BYTE, 2'd0, 32'hff, 1'b0, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h00, 1'b0, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h00, 1'b0, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h02, 1'b0, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'ha5, 1'b0, 1'b0, NO_RESULT},
        '{STEP_BYTE, 2'd0, 32'h5a, 1'b0, 1'b0, NO_RESULT}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   sink_ready = 1'b0;

    lpd_rx_if  rx_ch ();
    lpd_res_if res_ch ();

    assign res_ch.ready = sink_ready;

    length_prefixed_link_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx        (rx_ch),
        .o_res       (res_ch)
    );

    // Register copies and deframer state of the behavioral model
    logic [15:0] cfg_max_len   = MAX_PAYLOAD_LEN_RST;
    logic [31:0] cfg_ident     = LINK_IDENTIFIER_RST;
    logic [15:0] cfg_min_major = MIN_MAJOR_VERSION_RST;

    t_phase      dp_phase     = PH_HANDSHAKE;
    logic [3:0]  dp_count     = '0;
    logic        dp_reject    = 1'b0;
    logic [7:0]  dp_ver_high  = '0;
    logic [7:0]  dp_status    = '0;
    logic [7:0]  dp_len_high  = '0;
    logic [15:0] dp_length    = '0;
    logic [15:0] dp_remaining = '0;

    t_frame_result pending_results [$];
    int            mismatches     = 0;
    int            src_idle_pct   = 0;
    int            sink_stall_pct = 0;
    int            quiet_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    task automatic deframe_byte(input logic [7:0] b, output bit produced,
                                output t_frame_result r);
        logic is_last;
        produced = 1'b0;
        r        = NO_RESULT;
        case (dp_phase)
            PH_HANDSHAKE: begin
                if (dp_count < HS_CMD_FIRST) begin
                    if (b != cfg_ident[(3 - dp_count) * 8 +: 8]) dp_reject = 1'b1;
                end else if (dp_count < HS_VER_FIRST) begin
                    if (b != 8'h00) dp_reject = 1'b1;
                end else if (dp_count == HS_VER_HIGH) begin
                    dp_ver_high = b;
                end else if (dp_count == HS_VER_LOW) begin
                    if ({dp_ver_high, b} < cfg_min_major) dp_reject = 1'b1;
                end
                if (dp_count == HS_LAST) begin
                    produced = 1'b1;
                    r.kind   = dp_reject ? KIND_HS_REJECT : KIND_HS_ACCEPT;
                    dp_phase = dp_reject ? PH_ERROR : PH_HEADER;
                    dp_count = '0;
                end else begin
                    dp_count = dp_count + 4'd1;
                end
            end
            PH_HEADER: begin
                if (dp_count == HDR_STATUS) begin
                    dp_status = b;
                end else if (dp_count == HDR_LEN_HIGH) begin
                    dp_len_high = b;
                end
                if (dp_count >= HDR_LEN_LOW) begin
                    dp_length = {dp_len_high, b};
                    dp_count  = '0;
                    if (dp_length > cfg_max_len) begin
                        produced = 1'b1;
                        r        = '{KIND_LEN_ERROR, 8'h00, dp_status, 1'b0, dp_length};
                        dp_phase = PH_ERROR;
                    end else if (dp_length == 16'd0) begin
                        produced = 1'b1;
                        r        = '{KIND_EMPTY, 8'h00, dp_status, 1'b1, 16'd0};
                    end else begin
                        dp_remaining = dp_length;
                        dp_phase     = PH_PAYLOAD;
                    end
                end else begin
                    dp_count = dp_count + 4'd1;
                end
            end
            PH_PAYLOAD: begin
                is_last      = (dp_remaining <= 16'd1);
                produced     = 1'b1;
                r            = '{KIND_PAYLOAD, b, dp_status, is_last, dp_length};
                dp_remaining = dp_remaining - 16'd1;
                if (is_last) begin
                    dp_remaining = '0;
                    dp_phase     = PH_HEADER;
                    dp_count     = '0;
                end
            end
            default: begin
                // error phase swallows everything
            end
        endcase
    endtask

    // Drives one byte, holding valid until the transfer, then records what the
    // deframer should answer. A fixed row supplies its own expected result.
    task automatic send_byte(input logic [7:0] b, input bit fixed = 1'b0,
                             input bit fixed_has = 1'b0,
                             input t_frame_result fixed_res = NO_RESULT);
        bit            produced;
        t_frame_result r;
        while ($urandom_range(99) < src_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        deframe_byte(b, produced, r);
        if (fixed) begin
            if (fixed_has) pending_results.push_back(fixed_res);
        end else if (produced) begin
            pending_results.push_back(r);
        end
    endtask

    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MAX_PAYLOAD_LEN:   cfg_max_len   = value[15:0];
            REG_LINK_IDENTIFIER:   cfg_ident     = value;
            REG_MIN_MAJOR_VERSION: cfg_min_major = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_header(input logic [15:0] len);
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_frame(input logic [15:0] len);
        send_header(len);
        repeat (int'(len)) send_byte(8'($urandom_range(255)));
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct,
                             input logic [15:0] max_len, input logic [31:0] ident,
                             input logic [15:0] min_major, input int max_frame,
                             input int long_len, input int budget);
        int          sent;
        int          cap;
        int          roll;
        logic [15:0] len;
        settle();
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        cfg_write(REG_MAX_PAYLOAD_LEN, {16'h0, max_len});
        cfg_write(REG_LINK_IDENTIFIER, ident);
        cfg_write(REG_MIN_MAJOR_VERSION, {16'h0, min_major});
        cfg_write(REG_UNMAPPED, $urandom);
        cap  = (int'(max_len) < max_frame) ? int'(max_len) : max_frame;
        sent = 0;
        if (long_len > 0) begin
            send_frame(16'(long_len));
            sent = long_len + 4;
        end
        while (sent < budget) begin
            roll = $urandom_range(99);
            if (cap == 0 || roll < 10) len = 16'd0;
            else if (roll < 20)        len = 16'(cap);
            else                       len = 16'($urandom_range(cap, 1));
            send_frame(len);
            sent += int'(len) + 4;
        end
    endtask

    // Result sink: random stalls
    always @(posedge i_clk) begin
        sink_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got kind %0d data 0x%0h",
                         $time, res_ch.kind, res_ch.data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(res_ch.kind));
                check_field("data", 32'(want.data), 32'(res_ch.data));
                check_field("frame_status", 32'(want.status), 32'(res_ch.frame_status));
                check_field("last", 32'(want.last), 32'(res_ch.last));
                check_field("frame_length", 32'(want.length), 32'(res_ch.frame_length));
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [15:0] err_len;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].op == STEP_REG) begin
                settle();
                cfg_write(script[k].reg_idx, script[k].value);
            end else begin
                send_byte(script[k].value[7:0], script[k].fixed, script[k].has_res,
                          script[k].res);
            end
        end

        // identifier and version registers no longer matter after the handshake,
        // but each phase still rewrites them
        run_phase(0, 0, 16'd0, 32'hffff_ffff, 16'd0, 0, 0, 120);
        run_phase(70, 0, 16'hffff, $urandom, 16'hffff, 24, $urandom_range(280, 256), 230);
        run_phase(0, 70, 16'($urandom_range(40, 1)), 32'h0, 16'($urandom), 40, 0, 160);
        run_phase(25, 25, MAX_PAYLOAD_LEN_RST, LINK_IDENTIFIER_RST, 16'd1, 32,
                  $urandom_range(280, 256), 230);
        run_phase(0, 0, 16'd1, $urandom, 16'($urandom), 1, 0, 160);

        // oversized length: just past the limit or the largest one, then the
        // deframer must swallow everything
        err_len = $urandom_range(1) ? 16'd2 : 16'hffff;
        send_header(err_len);
        repeat (20) send_byte(8'($urandom_range(255)));

        settle();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
